FILE: hw/rtl/duplicate_message_filter_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Duplicate message filter table: assertion macros
// Shared assertion forms for the checker of the filter table unit.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_MESSAGE_FILTER_TABLE_UNIT_DEFINES_SVH
`define DUPLICATE_MESSAGE_FILTER_TABLE_UNIT_DEFINES_SVH

// Property checked at every rising edge, switched off while reset is held.
`define DMFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define DMFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/dmft_pkg.sv
// ----------------------------------------------------------------------------
// Duplicate message filter table: package
// Operation and status codes, and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package dmft_pkg;

  localparam int DIGEST_W = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Operation codes carried on in_action.
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;

  // Result codes carried on out_status.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the incoming word and restart the slot counter
    logic clear;   // write an empty entry at the slot counter
    logic scan;    // read the entry at the slot counter
    logic commit;  // update the chosen slot and present the result
  } dmft_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;  // slot counter points at the last slot
  } dmft_sts_t;

endpackage

FILE: hw/rtl/dmft_ctrl.sv
// ----------------------------------------------------------------------------
// Duplicate message filter table: controller
// Sequences the clearing pass after reset and the scan, drain and commit
// steps of each operation.
// ----------------------------------------------------------------------------
module dmft_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dmft_pkg::dmft_sts_t sts,
  output logic                busy,
  output dmft_pkg::dmft_cmd_t cmd
);
  import dmft_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_CLEAR: begin
        if (sts.addr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.addr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.commit = (state_r == ST_COMMIT);

endmodule

FILE: hw/rtl/dmft_datapath.sv
// ----------------------------------------------------------------------------
// Duplicate message filter table: datapath
// Entry memory, slot counter, per-entry match logic and the result register.
// ----------------------------------------------------------------------------
module dmft_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dmft_pkg::dmft_cmd_t                  cmd,
  output dmft_pkg::dmft_sts_t                  sts,
  input  logic [dmft_pkg::ACTION_W-1:0]        in_action,
  input  logic [dmft_pkg::DIGEST_W-1:0]        in_header_digest,
  input  logic [dmft_pkg::DIGEST_W-1:0]        in_ident_digest,
  output logic                                 out_strobe,
  output logic [dmft_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_is_duplicate
);
  import dmft_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic                live;
    logic [DIGEST_W-1:0] header;
    logic [DIGEST_W-1:0] ident;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  logic [AW-1:0]       addr_r;
  logic [ACTION_W-1:0] act_r;
  logic [DIGEST_W-1:0] hd_r;
  logic [DIGEST_W-1:0] id_r;
  entry_t              rd_q;
  logic                rd_pend_r;
  logic [AW-1:0]       rd_addr_r;
  logic                hit_r;
  logic [AW-1:0]       slot_r;
  logic                out_strobe_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_dup_r;

  logic                cond;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic [STATUS_W-1:0] status_nxt;

  assign sts.addr_last = (addr_r == AW'(TABLE_DEPTH - 1));

  // Match test on the entry read in the previous cycle.
  always_comb begin
    cond = 1'b0;
    unique case (act_r)
      ACT_ADD:    cond = !rd_q.live;
      ACT_REMOVE: cond = rd_q.live && (rd_q.header == hd_r) && (rd_q.ident == id_r);
      ACT_CHECK:  cond = rd_q.live &&
                         (((hd_r != '0) && (rd_q.header == hd_r)) ||
                          ((id_r != '0) && (rd_q.ident == id_r)));
      default:    cond = 1'b0;
    endcase
  end

  // One write port: the clearing pass, or the commit of an add or remove.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = '{live: 1'b0, header: hd_r, ident: id_r};
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = addr_r;
    end else if (cmd.commit && hit_r) begin
      wr_en        = (act_r == ACT_ADD) || (act_r == ACT_REMOVE);
      wr_data.live = (act_r == ACT_ADD);
    end
  end

  always_comb begin
    status_nxt = STATUS_OK;
    if ((act_r == ACT_ADD) && !hit_r) begin
      status_nxt = STATUS_FULL;
    end else if ((act_r == ACT_REMOVE) && !hit_r) begin
      status_nxt = STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan) begin
      rd_q <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      rd_pend_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      rd_pend_r    <= cmd.scan;
      out_strobe_r <= cmd.commit;
      if (cmd.load) begin
        addr_r <= '0;
        hit_r  <= 1'b0;
      end else begin
        if (cmd.clear || cmd.scan) begin
          addr_r <= addr_r + AW'(1);
        end
        if (rd_pend_r && cond && !hit_r) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      hd_r  <= in_header_digest;
      id_r  <= in_ident_digest;
    end
    if (cmd.scan) begin
      rd_addr_r <= addr_r;
    end
    if (rd_pend_r && cond && !hit_r) begin
      slot_r <= rd_addr_r;
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_dup_r    <= (act_r == ACT_CHECK) && hit_r;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_is_duplicate = out_dup_r;

endmodule

FILE: hw/rtl/duplicate_message_filter_table_unit.sv
// ----------------------------------------------------------------------------
// Duplicate message filter table unit
// Each word runs through the scan, drain and commit steps before out_strobe
// shows its result; the next word is taken only once the block is idle again,
// since each operation reads every slot once through the single read port
// of the entry memory. Reset (synchronous, rst_n low) starts a clearing pass
// over every slot with busy high; results are never stalled by the receiver.
// ----------------------------------------------------------------------------
module duplicate_message_filter_table_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dmft_pkg::ACTION_W-1:0]  in_action,
  input  logic [dmft_pkg::DIGEST_W-1:0]  in_header_digest,
  input  logic [dmft_pkg::DIGEST_W-1:0]  in_ident_digest,
  output logic                           out_strobe,
  output logic [dmft_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_is_duplicate
);
  import dmft_pkg::*;

  // The controller steps through the slots and the datapath does the work.
  // Every entry of the memory carries its own live flag, so the clearing
  // pass after reset is what makes the whole table read as empty; the
  // digest fields of a dead entry are never looked at.
  //
  // An operation runs as follows. The word is latched when start is seen
  // in the idle state. The scan then issues one read per cycle, slot zero
  // first. Each entry comes back in the next cycle and is tested against the
  // latched digests; the first slot that passes is remembered. An add
  // looks for a dead slot, a remove for a live slot whose pair matches
  // exactly, and a check for a live slot matching either nonzero digest.
  // After a drain step for the last read, the commit step writes the
  // chosen slot (live for an add, dead for a remove) and loads the result
  // register, which shows the result for one cycle on out_strobe.

  dmft_cmd_t cmd;
  dmft_sts_t sts;

  dmft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  dmft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_header_digest (in_header_digest),
    .in_ident_digest  (in_ident_digest),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_is_duplicate (out_is_duplicate)
  );

endmodule

FILE: hw/rtl/dmft_checker.sv
// ----------------------------------------------------------------------------
// Duplicate message filter table: port checker
// Watches the top-level ports of the filter table unit over time.
// ----------------------------------------------------------------------------
`include "duplicate_message_filter_table_unit_defines.svh"

module dmft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic [dmft_pkg::STATUS_W-1:0]  out_status,
  input logic                           out_is_duplicate
);
  import dmft_pkg::*;

  `DMFT_ASSERT(a_accept_goes_busy, clk, rst_n, (start && !busy) |=> busy, "accepted word did not raise busy")
  `DMFT_ASSERT(a_result_when_idle, clk, rst_n, out_strobe |-> !busy, "result shown while busy")
  `DMFT_ASSERT(a_single_result, clk, rst_n, out_strobe |=> !out_strobe, "result strobe lasted two cycles")
  `DMFT_ASSERT(a_dup_status_ok, clk, rst_n, (out_strobe && out_is_duplicate) |-> (out_status == STATUS_OK), "duplicate flag with error status")

endmodule

bind duplicate_message_filter_table_unit dmft_checker u_dmft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_is_duplicate (out_is_duplicate)
);

FILE: test/duplicate_message_filter_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate message filter table unit: testbench
// Sends add, remove, check and unused words to the filter table, first from a
// short table of directed cases and then from random sequences that fill the
// table to the top, hold it there, drain it and fill it again. Every result
// word is compared with a prediction, typed in or kept by a software copy of the table.
// ----------------------------------------------------------------------------
module duplicate_message_filter_table_unit_test;
  import dmft_pkg::*;

  localparam int TABLE_DEPTH     = 256;
  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 4;
  localparam int ITEMS_PER_PHASE = 375;
  // The slowest correct run is about 1525 words, each a full scan of the table,
  // plus sender gaps; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT     = 1_500_000;

  // The one action code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DIGEST_W-1:0] digest_t;

  typedef struct packed {
    status_t status;
    logic    is_dup;
  } verdict_t;

  // One directed word. Where fixed is set, the verdict is typed in here;
  // elsewhere it comes from the table copy.
  typedef struct packed {
    action_t  act;
    digest_t  hdr;
    digest_t  idt;
    logic     fixed;
    verdict_t verdict;
  } directed_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  action_t in_action;
  digest_t in_header_digest;
  digest_t in_ident_digest;
  logic out_strobe;
  status_t out_status;
  logic out_is_duplicate;

  // Software copy of the entry store.
  digest_t hdr_mem [TABLE_DEPTH];
  digest_t id_mem [TABLE_DEPTH];
  bit slot_live [TABLE_DEPTH];
  int unsigned live_count = 0;

  verdict_t pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int idle_pct = 0;

  directed_word_t directed_words [N_DIRECTED] = '{
    // An empty table after reset: nothing to remove, nothing found.
    '{ACT_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'h0000_0001, 32'h0000_0001, 1'b1, '{STATUS_NOT_FOUND, 1'b0}},
    '{ACT_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,        1'b0}},
    // All-ones pair, found through either half alone.
    '{ACT_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{STATUS_OK,        1'b1}},
    '{ACT_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,        1'b1}},
    // A zero pair is stored, but zero digests never match on a check.
    '{ACT_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK,        1'b0}},
    // A digest only matches in its own column.
    '{ACT_ADD,    32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h0000_0000, 32'h1234_5678, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    // Two equal pairs: each remove frees one, the last one stops matching.
    '{ACT_ADD,    32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h1234_5678, 32'h0000_0005, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h1234_5678, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    // The zero pair can still be removed, but only once.
    '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_NOT_FOUND, 1'b0}},
    // The unused action changes nothing and reports OK with no duplicate.
    '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,        1'b0}},
    // A remove needs both halves to match.
    '{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{STATUS_NOT_FOUND, 1'b0}},
    '{ACT_ADD,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_CHECK,  32'h8000_0000, 32'h5555_5555, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{STATUS_OK,        1'b0}},
    '{ACT_REMOVE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{STATUS_OK,        1'b0}}
  };

  duplicate_message_filter_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_header_digest(in_header_digest),
    .in_ident_digest(in_ident_digest),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_is_duplicate(out_is_duplicate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one word to the table copy and returns the verdict it yields.
  function automatic verdict_t apply_filter_op(action_t act, digest_t h, digest_t m);
    verdict_t v;
    int slot;
    v.status = STATUS_OK;
    v.is_dup = 1'b0;
    slot = -1;
    case (act)
      ACT_ADD: begin
        // Lowest free slot takes the pair.
        for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
          if (!slot_live[i]) slot = i;
        if (slot < 0) begin
          v.status = STATUS_FULL;
        end else begin
          hdr_mem[slot] = h;
          id_mem[slot] = m;
          slot_live[slot] = 1'b1;
          live_count++;
        end
      end
      ACT_REMOVE: begin
        // Exact match on both halves, zero included; lowest slot first.
        for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
          if (slot_live[i] && hdr_mem[i] == h && id_mem[i] == m) slot = i;
        if (slot < 0) begin
          v.status = STATUS_NOT_FOUND;
        end else begin
          slot_live[slot] = 1'b0;
          live_count--;
        end
      end
      ACT_CHECK: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot_live[i] && ((h != '0 && hdr_mem[i] == h) || (m != '0 && id_mem[i] == m)))
            v.is_dup = 1'b1;
      end
      default: ;
    endcase
    return v;
  endfunction

  // A live slot picked at random, or -1 when the table is empty.
  function automatic int pick_live_slot();
    int base;
    if (live_count == 0) return -1;
    base = $urandom_range(TABLE_DEPTH - 1);
    for (int k = 0; k < TABLE_DEPTH; k++)
      if (slot_live[(base + k) % TABLE_DEPTH]) return (base + k) % TABLE_DEPTH;
    return -1;
  endfunction

  // Digest mix: zero, all ones, small values and single bits show up often
  // enough to be hit on purpose; the rest is full-width random.
  function automatic digest_t random_digest();
    int pick;
    pick = $urandom_range(19);
    case (pick)
      0, 1:    return '0;
      2:       return '1;
      3, 4:    return digest_t'($urandom_range(15, 1));
      5:       return digest_t'(1) << $urandom_range(DIGEST_W - 1);
      default: return digest_t'($urandom);
    endcase
  endfunction

  // Offers one word and returns once the block has taken it. In each cycle
  // the word is offered or withheld at random according to idle_pct, so the
  // acceptance edge wanders across the end of the busy period.
  task automatic issue_word(input action_t act, input digest_t h, input digest_t m,
                            input logic fixed, input verdict_t fixed_verdict);
    verdict_t v;
    bit offered;
    offered = 1'b0;
    forever begin
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct) begin
        if (!offered) begin
          start <= 1'b1;
          in_action <= act;
          in_header_digest <= h;
          in_ident_digest <= m;
          offered = 1'b1;
        end
      end else begin
        start <= 1'b0;
        offered = 1'b0;
      end
      @(posedge clk);
      if (offered && !busy) break;
    end
    // The table copy is updated for every word, typed verdict or not.
    v = apply_filter_op(act, h, m);
    if (fixed) v = fixed_verdict;
    pending_verdicts.push_back(v);
  endtask

  // Result words are compared with the oldest outstanding verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("out_strobe: result word with no word outstanding");
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_is_duplicate !== want.is_dup) begin
          $error("out_is_duplicate: expected %0d, got %0d", want.is_dup, out_is_duplicate);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    action_t act;
    digest_t h;
    digest_t m;
    int roll;
    int slot;
    int add_pct;
    int rm_pct;
    int chk_pct;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_ADD;
    in_header_digest <= '0;
    in_ident_digest <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first word is offered while the clearing pass still holds busy.
    idle_pct = 0;
    foreach (directed_words[i])
      issue_word(directed_words[i].act, directed_words[i].hdr, directed_words[i].idt,
                 directed_words[i].fixed, directed_words[i].verdict);

    // Phases: fill to the top with no gaps, churn near full with a mostly
    // idle sender, drain with some gaps, then refill with no gaps.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  add_pct = 80; rm_pct = 8;  chk_pct = 10; end
        1:       begin idle_pct = 84; add_pct = 45; rm_pct = 25; chk_pct = 28; end
        2:       begin idle_pct = 34; add_pct = 15; rm_pct = 55; chk_pct = 28; end
        default: begin idle_pct = 0;  add_pct = 50; rm_pct = 25; chk_pct = 23; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < add_pct) act = ACT_ADD;
        else if (roll < add_pct + rm_pct) act = ACT_REMOVE;
        else if (roll < add_pct + rm_pct + chk_pct) act = ACT_CHECK;
        else act = ACT_UNUSED;
        h = random_digest();
        m = random_digest();
        slot = pick_live_slot();
        roll = $urandom_range(99);
        // Digests are mostly borrowed from live slots so that removes and
        // checks find something; the rest stay random and mostly miss.
        case (act)
          ACT_ADD: begin
            if (slot >= 0 && roll < 15) begin
              h = hdr_mem[slot];
              m = id_mem[slot];
            end
          end
          ACT_REMOVE: begin
            if (slot >= 0) begin
              if (roll < 75) begin
                h = hdr_mem[slot];
                m = id_mem[slot];
              end else if (roll < 85) begin
                h = hdr_mem[slot];
              end else if (roll < 90) begin
                m = id_mem[slot];
              end
            end
          end
          ACT_CHECK: begin
            if (slot >= 0) begin
              if (roll < 35) h = hdr_mem[slot];
              else if (roll < 70) m = id_mem[slot];
            end
          end
          default: ;
        endcase
        issue_word(act, h, m, 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    // Watch for stray result words for one more operation time.
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
